// ----- rtl/core/dht_pkg.sv -----
// Shared types and constants for the displacement heading tracker.
// Holds the CORDIC arctangent table, fixed-point constants and the
// controller/datapath interface structs. No dependencies.
`default_nettype none

package dht_pkg;

	// Arctangent table in binary angle units (2^32 is one full turn).
	localparam int ATAN_LEN = 24;
	localparam int IDX_W    = 5;

	localparam logic [31:0] ATAN_TABLE [ATAN_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// pi scaled by 2^29, used to turn binary angle units into Q2.13 radians.
	localparam logic [30:0] PI_Q29        = 31'd1686629713;
	localparam logic [14:0] HEADING_MAX   = 15'd25736;
	localparam logic [30:0] THRESH_RESET  = 31'd6554;

	// Register index decoded from the APB address.
	localparam logic REG_THRESHOLD = 1'b0;

	// Datapath widths: differences are exact in 33 bits, CORDIC growth needs 36.
	localparam int D_W  = 33;
	localparam int XY_W = 36;
	localparam int Z_W  = 34;
	localparam int P_W  = 65;

	typedef struct packed {
		logic             load;
		logic             prep;
		logic             iter;
		logic             mul;
		logic             fin;
		logic [IDX_W-1:0] idx;
	} dht_cmd_t;

	typedef struct packed {
		logic skip;
		logic out_free;
	} dht_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/displacement_heading_tracker.sv -----
// Top level of the displacement heading tracker: APB register, controller
// and datapath. Depends on dht_pkg, dht_ctrl and dht_dp.
`default_nettype none

// Each accepted transaction is one trajectory point; exactly one result
// (heading_angle in Q2.13 radians, step_valid) comes out per point, in order.
// A point whose step is valid and has a nonzero dy runs the shared CORDIC
// vectoring stage once per iteration, going through prepare, the iterations,
// scaling and the final write; other points go from prepare straight to the
// final write. CORDIC_STEPS above 24 behaves as 24. The input is stalled
// while a point is in work; a finished result waits in the output register
// and blocks only the final write of the next point. The threshold register
// (address 0) should be written only while the block is idle.

module displacement_heading_tracker
	import dht_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic        [2:0]  paddr,
	input  wire logic        [31:0] pwdata,
	output logic             [31:0] prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic               anchor_start,
	input  wire logic signed [31:0] origin_x,
	input  wire logic signed [31:0] origin_y,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      heading_angle,
	output logic                    step_valid
);

	localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

	logic [30:0] threshold_q;
	logic        reg_idx;
	dht_cmd_t    cmd;
	dht_sts_t    sts;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESH_RESET;
		end else if (psel && penable && pwrite && reg_idx == REG_THRESHOLD) begin
			threshold_q <= pwdata[30:0];
		end
	end

	always_comb begin
		case (reg_idx)
			REG_THRESHOLD: prdata = {1'b0, threshold_q};
			default:       prdata = '0;
		endcase
	end

	dht_ctrl #(
		.STEPS(STEPS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	dht_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.threshold    (threshold_q),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.anchor_start (anchor_start),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.heading_angle(heading_angle),
		.step_valid   (step_valid)
	);

endmodule

`default_nettype wire

// ----- rtl/core/dht_ctrl.sv -----
// Sequencer for the displacement heading tracker.
// Steps one transaction through prepare, CORDIC iterations, scaling and output;
// a skipped point goes from prepare straight to output. Depends on dht_pkg.
`default_nettype none

module dht_ctrl
	import dht_pkg::*;
#(
	parameter int STEPS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire dht_sts_t sts,
	output dht_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_ITER = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STEPS - 1);

	logic [2:0]       state_q, state_d;
	logic [IDX_W-1:0] cnt_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_PREP;
			S_PREP: state_d = sts.skip ? S_FIN : S_ITER;
			S_ITER: if (cnt_q == LAST_IDX) state_d = S_MUL;
			S_MUL:  state_d = S_FIN;
			S_FIN:  if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_ITER)
				cnt_q <= cnt_q + IDX_W'(1);
			else
				cnt_q <= '0;
		end
	end

	always_comb begin
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.prep = (state_q == S_PREP);
		cmd.iter = (state_q == S_ITER);
		cmd.mul  = (state_q == S_MUL);
		cmd.fin  = (state_q == S_FIN) && sts.out_free;
		cmd.idx  = cnt_q;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER) |-> (cnt_q <= LAST_IDX))
		else $error("iteration counter ran past the last step");

	a_load_prep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_PREP))
		else $error("accepted transaction did not move to prepare");

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> sts.out_free)
		else $error("result written while the output register was occupied");

endmodule

`default_nettype wire

// ----- rtl/core/dht_dp.sv -----
// Datapath of the displacement heading tracker: differences, CORDIC
// vectoring stage, angle scaling and the output register.
// Depends on dht_pkg; driven by dht_ctrl commands.
`default_nettype none

module dht_dp
	import dht_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dht_cmd_t           cmd,
	output dht_sts_t                sts,
	input  wire logic        [30:0] threshold,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic               anchor_start,
	input  wire logic signed [31:0] origin_x,
	input  wire logic signed [31:0] origin_y,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      heading_angle,
	output logic                    step_valid
);

	logic signed [31:0]     prev_x_q, prev_y_q;
	logic signed [D_W-1:0]  dx_q, dy_q;
	logic                   start_q, valid_q, dyzero_q, neg_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]  z_q;
	logic [P_W-1:0]         prod_q;
	logic signed [15:0]     held_q, heading_q;
	logic                   out_valid_q, step_valid_q;

	logic signed [31:0]     base_x, base_y;
	logic signed [D_W-1:0]  thr_s;
	logic                   valid_c, dyzero_c;
	logic signed [XY_W-1:0] xs, ys;
	logic signed [Z_W-1:0]  atan_s;
	logic [Z_W-1:0]         zabs;
	logic [P_W-1:0]         rnd;
	logic [17:0]            q_c;
	logic [14:0]            mag_c;
	logic signed [15:0]     cordic_hd, heading_c;

	assign base_x = anchor_start ? origin_x : prev_x_q;
	assign base_y = anchor_start ? origin_y : prev_y_q;

	// The threshold is compared against the signed differences as they are.
	assign thr_s    = $signed({2'b00, threshold});
	assign valid_c  = (dx_q > thr_s) || (dy_q > thr_s);
	assign dyzero_c = (dy_q == '0);

	assign xs     = x_q >>> cmd.idx;
	assign ys     = y_q >>> cmd.idx;
	assign atan_s = $signed({2'b00, ATAN_TABLE[cmd.idx]});

	assign zabs = z_q[Z_W-1] ? Z_W'(-z_q) : Z_W'(z_q);

	// Round half away from zero on the magnitude, then saturate.
	assign rnd       = prod_q + (P_W'(1) << 46);
	assign q_c       = rnd[P_W-1:47];
	assign mag_c     = (q_c > 18'(HEADING_MAX)) ? HEADING_MAX : q_c[14:0];
	assign cordic_hd = neg_q ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});

	always_comb begin
		if (!valid_q)
			heading_c = start_q ? 16'sd0 : held_q;
		else if (dyzero_q)
			heading_c = 16'sd0;
		else
			heading_c = cordic_hd;
	end

	assign sts.skip     = !valid_c || dyzero_c;
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				prev_x_q <= pos_x;
				prev_y_q <= pos_y;
			end
			if (cmd.fin) begin
				held_q      <= heading_c;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q    <= D_W'(pos_x) - D_W'(base_x);
			dy_q    <= D_W'(pos_y) - D_W'(base_y);
			start_q <= anchor_start;
		end
		if (cmd.prep) begin
			valid_q  <= valid_c;
			dyzero_q <= dyzero_c;
			// A vector in the left half plane is turned by half a turn first.
			if (dx_q[D_W-1]) begin
				x_q <= -XY_W'(dx_q);
				y_q <= -XY_W'(dy_q);
				z_q <= dy_q[D_W-1] ? -(Z_W'(1) <<< 31) : (Z_W'(1) <<< 31);
			end else begin
				x_q <= XY_W'(dx_q);
				y_q <= XY_W'(dy_q);
				z_q <= '0;
			end
		end
		if (cmd.iter) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_s;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_s;
			end
		end
		if (cmd.mul) begin
			prod_q <= P_W'(zabs) * P_W'(PI_Q29);
			neg_q  <= z_q[Z_W-1];
		end
		if (cmd.fin) begin
			heading_q    <= heading_c;
			step_valid_q <= valid_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign heading_angle = heading_q;
	assign step_valid    = step_valid_q;

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (heading_c >= -16'sd25736 && heading_c <= 16'sd25736))
		else $error("heading left the Q2.13 range of plus or minus pi");

endmodule

`default_nettype wire
